[rtl/core/lspe_pkg.sv]
// Shared constants, widths and types of the line sensor position estimator.
// No dependencies; the frame store, the estimator and the testbench import this package.
package lspe_pkg;

    localparam int NUM_SENSORS  = 8;
    localparam int ADC_BITS_DEF = 12;
    localparam int FULL_SCALE   = 1000;

    localparam int VAL_W  = $clog2(FULL_SCALE + 1);
    localparam int IDX_W  = $clog2(NUM_SENSORS);
    localparam int VSUM_W = $clog2(NUM_SENSORS * FULL_SCALE + 1);
    localparam int WSUM_W = $clog2(FULL_SCALE * NUM_SENSORS * (NUM_SENSORS - 1) / 2 + 1);
    localparam int WNUM_W = WSUM_W + VAL_W;
    localparam int MAX_POS = (NUM_SENSORS - 1) * FULL_SCALE;
    localparam int POS_Q_W = $clog2(MAX_POS + 1);

    localparam int POS_W   = 13;
    localparam int POS_SAT = 8191;
    localparam int THR_W   = 10;
    localparam int CFG_W   = 13;
    localparam int CIDX_W  = 2;

    localparam int CENTER_RST = 3500;
    localparam int THR_RST    = 200;
    localparam int LAST_RST   = 3500;

    localparam logic [CIDX_W-1:0] REG_LINE_IS_WHITE    = 2'd0;
    localparam logic [CIDX_W-1:0] REG_CENTER_POSITION  = 2'd1;
    localparam logic [CIDX_W-1:0] REG_DETECT_THRESHOLD = 2'd2;

    localparam logic CMD_CALIBRATE = 1'b0;
    localparam logic CMD_MEASURE   = 1'b1;

    // control of the rotating frame and calibration store
    typedef struct packed {
        logic load;
        logic rotate;
        logic update;
    } cal_ctrl_t;

endpackage

[rtl/core/lspe_serdiv.sv]
// Restoring divider, one quotient bit per cycle.
// Stand-alone; the caller guarantees the quotient fits in Q_W bits.
module lspe_serdiv #(
    parameter int REM_W = 12,
    parameter int Q_W   = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [REM_W-1:0] rem_init,
    input  logic [Q_W-1:0]   num_lo,
    input  logic [REM_W-1:0] divisor,
    output logic             done,
    output logic [Q_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(Q_W);

    logic [REM_W-1:0] rem_reg, rem_next;
    logic [Q_W-1:0]   sh_reg, sh_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [REM_W:0]   trial;
    logic [REM_W:0]   diff;
    logic             ge;

    assign trial = {rem_reg, sh_reg[Q_W-1]};
    assign ge    = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = rem_init;
            sh_next   = num_lo;
            cnt_next  = CNT_W'(Q_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // partial remainder stays below the divisor, so REM_W bits hold it
            rem_next = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
            sh_next  = {sh_reg[Q_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
    end

    assign done     = done_reg;
    assign quotient = sh_reg;

endmodule

[rtl/core/lspe_frame_store.sv]
// Rotating store of the current frame and the per-sensor calibration range.
// Depends on lspe_pkg for the sensor count and the control struct.
module lspe_frame_store
    import lspe_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  cal_ctrl_t                             ctrl,
    input  logic [NUM_SENSORS-1:0][ADC_BITS-1:0]  frame,
    output logic [ADC_BITS-1:0]                   head_sample,
    output logic [ADC_BITS-1:0]                   head_min,
    output logic [ADC_BITS-1:0]                   head_max
);

    logic [NUM_SENSORS-1:0][ADC_BITS-1:0] samp_reg;
    logic [NUM_SENSORS-1:0][ADC_BITS-1:0] min_reg;
    logic [NUM_SENSORS-1:0][ADC_BITS-1:0] max_reg;
    logic [ADC_BITS-1:0]                  min_next;
    logic [ADC_BITS-1:0]                  max_next;

    assign head_sample = samp_reg[0];
    assign head_min    = min_reg[0];
    assign head_max    = max_reg[0];

    // widen the range at the head before it rotates to the tail
    always_comb
    begin
        min_next = min_reg[0];
        max_next = max_reg[0];
        if (ctrl.update)
        begin
            if (samp_reg[0] < min_reg[0])
                min_next = samp_reg[0];
            if (samp_reg[0] > max_reg[0])
                max_next = samp_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
            samp_reg <= frame;
        else if (ctrl.rotate)
            samp_reg <= {samp_reg[0], samp_reg[NUM_SENSORS-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= '1;
            max_reg <= '0;
        end
        else if (ctrl.rotate)
        begin
            min_reg <= {min_next, min_reg[NUM_SENSORS-1:1]};
            max_reg <= {max_next, max_reg[NUM_SENSORS-1:1]};
        end
    end

endmodule

[rtl/core/line_sensor_position_estimator.sv]
// Line sensor position estimator: calibrate or measure one frame of eight samples per item.
// A calibrate item rotates through the sensors to widen each range and gives no result. A
// measure item, per sensor, loads the sample, runs the bit-serial scaling divider, takes the
// quotient and accumulates; a sensor whose value is clamped skips the divider. Then a load
// step starts the bit-serial position divider, unless the line is lost, and an output step
// follows. One item is worked on at a time; the result sits in an output register, so a new
// item is accepted while it waits to be taken.
module line_sensor_position_estimator
    import lspe_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                command,
    input  logic [ADC_BITS-1:0] sample_0,
    input  logic [ADC_BITS-1:0] sample_1,
    input  logic [ADC_BITS-1:0] sample_2,
    input  logic [ADC_BITS-1:0] sample_3,
    input  logic [ADC_BITS-1:0] sample_4,
    input  logic [ADC_BITS-1:0] sample_5,
    input  logic [ADC_BITS-1:0] sample_6,
    input  logic [ADC_BITS-1:0] sample_7,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [POS_W-1:0]    position,
    output logic                line_lost,
    input  logic                cfg_we,
    input  logic [CIDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]    cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CAL   = 3'd1;
    localparam logic [2:0] ST_SLOAD = 3'd2;
    localparam logic [2:0] ST_SDIV  = 3'd3;
    localparam logic [2:0] ST_ACC   = 3'd4;
    localparam logic [2:0] ST_FLOAD = 3'd5;
    localparam logic [2:0] ST_FDIV  = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    localparam int NUM_W = ADC_BITS + VAL_W;

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NUM_SENSORS - 1);
    localparam logic [VAL_W-1:0] FULL_VAL  = VAL_W'(FULL_SCALE);
    localparam logic [POS_W-1:0] MAX_POS_C = POS_W'(MAX_POS);

    logic [2:0]              state_reg, state_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [VAL_W-1:0]        val_reg, val_next;
    logic                    on_line_reg, on_line_next;
    logic [VSUM_W-1:0]       vsum_reg, vsum_next;
    logic [WSUM_W-1:0]       wsum_reg, wsum_next;
    logic [POS_W-1:0]        last_pos_reg, last_pos_next;
    logic [POS_W-1:0]        res_pos_reg, res_pos_next;
    logic                    res_lost_reg, res_lost_next;
    logic [POS_W-1:0]        position_reg, position_next;
    logic                    lost_flag_reg, lost_flag_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    white_reg;
    logic [POS_W-1:0]        center_reg;
    logic [THR_W-1:0]        thr_reg;

    logic [NUM_SENSORS-1:0][ADC_BITS-1:0] frame;
    cal_ctrl_t               cal_ctrl;
    logic [ADC_BITS-1:0]     x, lo, hi;
    logic [ADC_BITS-1:0]     diff, span;
    logic [NUM_W-1:0]        scaled_num;
    logic                    sdiv_start, sdiv_done;
    logic [VAL_W-1:0]        sdiv_q;
    logic [VAL_W-1:0]        v_adj;
    logic [WNUM_W-1:0]       wnum;
    logic                    fdiv_start, fdiv_done;
    logic [POS_Q_W-1:0]      fdiv_q;
    logic                    in_fire;

    assign frame[0] = sample_0;
    assign frame[1] = sample_1;
    assign frame[2] = sample_2;
    assign frame[3] = sample_3;
    assign frame[4] = sample_4;
    assign frame[5] = sample_5;
    assign frame[6] = sample_6;
    assign frame[7] = sample_7;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;

    lspe_frame_store #(
        .ADC_BITS (ADC_BITS)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (cal_ctrl),
        .frame       (frame),
        .head_sample (x),
        .head_min    (lo),
        .head_max    (hi)
    );

    // times 1000 as 1024 - 16 - 8
    assign diff       = x - lo;
    assign span       = hi - lo;
    assign scaled_num = (NUM_W'(diff) << 10) - (NUM_W'(diff) << 4) - (NUM_W'(diff) << 3);
    assign sdiv_start = (state_reg == ST_SLOAD) && (x > lo) && (hi > lo) && (x < hi);

    lspe_serdiv #(
        .REM_W (ADC_BITS),
        .Q_W   (VAL_W)
    ) u_scale_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sdiv_start),
        .rem_init (scaled_num[NUM_W-1:VAL_W]),
        .num_lo   (scaled_num[VAL_W-1:0]),
        .divisor  (span),
        .done     (sdiv_done),
        .quotient (sdiv_q)
    );

    assign v_adj = white_reg ? (FULL_VAL - val_reg) : val_reg;

    assign wnum = (WNUM_W'(wsum_reg) << 10) - (WNUM_W'(wsum_reg) << 4)
                - (WNUM_W'(wsum_reg) << 3);
    assign fdiv_start = (state_reg == ST_FLOAD) && on_line_reg && (vsum_reg != '0);

    lspe_serdiv #(
        .REM_W (VSUM_W),
        .Q_W   (POS_Q_W)
    ) u_pos_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (fdiv_start),
        .rem_init (VSUM_W'(wnum[WNUM_W-1:POS_Q_W])),
        .num_lo   (wnum[POS_Q_W-1:0]),
        .divisor  (vsum_reg),
        .done     (fdiv_done),
        .quotient (fdiv_q)
    );

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        on_line_next   = on_line_reg;
        vsum_next      = vsum_reg;
        wsum_next      = wsum_reg;
        last_pos_next  = last_pos_reg;
        res_pos_next   = res_pos_reg;
        res_lost_next  = res_lost_reg;
        position_next  = position_reg;
        lost_flag_next = lost_flag_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cal_ctrl       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cal_ctrl.load = 1'b1;
                    idx_next      = '0;
                    on_line_next  = 1'b0;
                    vsum_next     = '0;
                    wsum_next     = '0;
                    state_next    = (command == CMD_MEASURE) ? ST_SLOAD : ST_CAL;
                end
            end
            ST_CAL:
            begin
                cal_ctrl.rotate = 1'b1;
                cal_ctrl.update = 1'b1;
                idx_next        = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_SLOAD:
            begin
                if (x <= lo)
                begin
                    val_next   = '0;
                    state_next = ST_ACC;
                end
                else if (!sdiv_start)
                begin
                    // empty range or sample at or past the maximum: clamp
                    val_next   = FULL_VAL;
                    state_next = ST_ACC;
                end
                else
                    state_next = ST_SDIV;
            end
            ST_SDIV:
            begin
                if (sdiv_done)
                begin
                    val_next   = sdiv_q;
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                cal_ctrl.rotate = 1'b1;
                vsum_next       = vsum_reg + VSUM_W'(v_adj);
                wsum_next       = wsum_reg + WSUM_W'(v_adj) * WSUM_W'(idx_reg);
                if (v_adj > thr_reg)
                    on_line_next = 1'b1;
                idx_next   = idx_reg + 1'b1;
                state_next = ST_SLOAD;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = ST_FLOAD;
                end
            end
            ST_FLOAD:
            begin
                if (fdiv_start)
                    state_next = ST_FDIV;
                else
                begin
                    res_pos_next  = (last_pos_reg < center_reg) ? '0 : MAX_POS_C;
                    res_lost_next = 1'b1;
                    state_next    = ST_OUT;
                end
            end
            ST_FDIV:
            begin
                if (fdiv_done)
                begin
                    res_pos_next  = (fdiv_q > POS_SAT) ? POS_W'(POS_SAT) : POS_W'(fdiv_q);
                    last_pos_next = res_pos_next;
                    res_lost_next = 1'b0;
                    state_next    = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    position_next  = res_pos_reg;
                    lost_flag_next = res_lost_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            last_pos_reg  <= POS_W'(LAST_RST);
            lost_flag_reg <= 1'b0;
            white_reg     <= 1'b0;
            center_reg    <= POS_W'(CENTER_RST);
            thr_reg       <= THR_W'(THR_RST);
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            last_pos_reg  <= last_pos_next;
            lost_flag_reg <= lost_flag_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LINE_IS_WHITE:    white_reg  <= cfg_data[0];
                    REG_CENTER_POSITION:  center_reg <= cfg_data[POS_W-1:0];
                    REG_DETECT_THRESHOLD: thr_reg    <= cfg_data[THR_W-1:0];
                    default:              ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg      <= val_next;
        on_line_reg  <= on_line_next;
        vsum_reg     <= vsum_next;
        wsum_reg     <= wsum_next;
        res_pos_reg  <= res_pos_next;
        res_lost_reg <= res_lost_next;
        position_reg <= position_next;
    end

    assign out_valid = out_valid_reg;
    assign position  = position_reg;
    assign line_lost = lost_flag_reg;

`ifndef NO_ASSERTIONS
    a_lost_extreme: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_lost |-> position == '0 || position == MAX_POS_C)
        else $error("lost-line result is not an extreme position");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while the previous one is still in work");

    a_sdiv_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        sdiv_done |-> state_reg == ST_SDIV)
        else $error("scaling divider finished outside its wait state");

    a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !line_lost |-> position <= MAX_POS_C)
        else $error("line position beyond the last sensor");
`endif

endmodule

[tb/line_sensor_position_estimator_tb.sv]
// Self-checking testbench for line_sensor_position_estimator: calibrate and measure frames.
// Depends on lspe_pkg and the block's RTL; it predicts each position fix and checks it.
`timescale 1ns / 1ps

module line_sensor_position_estimator_tb;
    import lspe_pkg::*;

    localparam int ADC_W         = ADC_BITS_DEF;
    localparam int ADC_TOP       = (1 << ADC_W) - 1;
    localparam int HOLD_OFF      = 150;
    localparam int STALL_LIMIT   = 4000;
    localparam int PHASE_FRAMES  = 627;
    localparam int CHUNK         = 90;
    localparam int REPORT_LIMIT  = 10;
    localparam logic [CIDX_W-1:0] REG_SPARE = 2'd3;

    typedef logic [NUM_SENSORS-1:0][ADC_W-1:0] frame_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             line_lost;
    } line_fix_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic              command;
    frame_t            frame_bus;
    logic              out_valid;
    logic              out_ready;
    logic [POS_W-1:0]  position;
    logic              line_lost;
    logic              cfg_we;
    logic [CIDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]  cfg_data;

    // predictor state and register copies
    logic [ADC_W-1:0]  cal_lo [NUM_SENSORS];
    logic [ADC_W-1:0]  cal_hi [NUM_SENSORS];
    logic [POS_W-1:0]  last_fix;
    logic              white_line;
    logic [POS_W-1:0]  centre_pos;
    logic [THR_W-1:0]  threshold;
    line_fix_t         expected_fixes [$];

    int send_idle_pct  = 0;
    int sink_stall_pct = 0;
    int fault_count    = 0;
    int stalled_cycles = 0;
    int measures_sent  = 0;
    int cal_frames     = 0;
    int reg_writes     = 0;
    int fixes_seen     = 0;
    int lost_seen      = 0;

    always #5 clk = ~clk;

    line_sensor_position_estimator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .sample_0  (frame_bus[0]),
        .sample_1  (frame_bus[1]),
        .sample_2  (frame_bus[2]),
        .sample_3  (frame_bus[3]),
        .sample_4  (frame_bus[4]),
        .sample_5  (frame_bus[5]),
        .sample_6  (frame_bus[6]),
        .sample_7  (frame_bus[7]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .position  (position),
        .line_lost (line_lost),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Widen the calibration on a calibrate item; on a measure item queue the expected fix.
    function automatic void estimate_position(logic cmd, frame_t fr);
        int unsigned     x;
        int unsigned     lo;
        int unsigned     hi;
        int unsigned     span;
        int unsigned     v;
        int unsigned     vsum;
        longint unsigned wsum;
        longint unsigned q;
        bit              seen;
        line_fix_t       fix;
        vsum = 0;
        wsum = 0;
        seen = 1'b0;
        if (cmd == CMD_CALIBRATE)
        begin
            for (int i = 0; i < NUM_SENSORS; i++)
            begin
                if (fr[i] < cal_lo[i])
                    cal_lo[i] = fr[i];
                if (fr[i] > cal_hi[i])
                    cal_hi[i] = fr[i];
            end
            return;
        end
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            x = fr[i];
            lo = cal_lo[i];
            hi = cal_hi[i];
            span = (hi > lo) ? hi - lo : 1;
            if (x <= lo)
                v = 0;
            else
            begin
                v = (x - lo) * FULL_SCALE / span;
                if (v > FULL_SCALE)
                    v = FULL_SCALE;
            end
            if (white_line)
                v = FULL_SCALE - v;
            if (v > threshold)
                seen = 1'b1;
            wsum += 64'(v) * 64'(i * FULL_SCALE);
            vsum += v;
        end
        if (!seen || vsum == 0)
        begin
            // line lost: push to the extreme on the side of the last fix
            fix.position  = (last_fix < centre_pos) ? '0 : POS_W'(MAX_POS);
            fix.line_lost = 1'b1;
        end
        else
        begin
            q = wsum / vsum;
            last_fix = (q > POS_SAT) ? POS_W'(POS_SAT) : POS_W'(q);
            fix.position  = last_fix;
            fix.line_lost = 1'b0;
        end
        expected_fixes.push_back(fix);
    endfunction

    function automatic frame_t flat_frame(int val);
        frame_t fr;
        for (int i = 0; i < NUM_SENSORS; i++)
            fr[i] = ADC_W'(val);
        return fr;
    endfunction

    function automatic frame_t noise_frame();
        frame_t fr;
        for (int i = 0; i < NUM_SENSORS; i++)
            fr[i] = ADC_W'($urandom_range(0, ADC_TOP));
        return fr;
    endfunction

    function automatic frame_t band_frame();
        frame_t fr;
        for (int i = 0; i < NUM_SENSORS; i++)
            fr[i] = ADC_W'($urandom_range(800, 3200));
        return fr;
    endfunction

    // A stripe of dark readings around a random sensor; mirrored for a light line.
    function automatic frame_t line_frame(logic light);
        frame_t fr;
        int     c;
        int     w;
        int     d;
        c = $urandom_range(0, NUM_SENSORS - 1);
        w = $urandom_range(0, 2);
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            d = (i > c) ? i - c : c - i;
            if (d <= w)
                fr[i] = ADC_W'($urandom_range(2600, ADC_TOP));
            else
                fr[i] = ADC_W'($urandom_range(0, 1400));
            if (light)
                fr[i] = ADC_W'(ADC_TOP) - fr[i];
        end
        return fr;
    endfunction

    // Entered just after a rising edge; returns at the edge that accepts the item.
    task automatic send_frame(input logic cmd, input frame_t fr);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        command   <= cmd;
        frame_bus <= fr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        estimate_position(cmd, fr);
        if (cmd == CMD_MEASURE)
            measures_sent++;
        else
            cal_frames++;
    endtask

    // Hold off until every fix is in, then let any calibrate item finish.
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_fixes.size() != 0)
            @(posedge clk);
        repeat (HOLD_OFF) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_LINE_IS_WHITE:    white_line = data[0];
            REG_CENTER_POSITION:  centre_pos = data;
            REG_DETECT_THRESHOLD: threshold  = data[THR_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic test_uncalibrated();
        // empty calibration: every sensor reads zero, or full scale on a light line
        send_frame(CMD_MEASURE, flat_frame(0));
        send_frame(CMD_MEASURE, flat_frame(ADC_TOP));
        write_reg(REG_LINE_IS_WHITE, CFG_W'(1));
        send_frame(CMD_MEASURE, flat_frame(1234));
        write_reg(REG_LINE_IS_WHITE, CFG_W'(0));
    endtask

    task automatic test_single_frame_calibration();
        frame_t fr;
        // minimum equals maximum: span of one, any step above saturates
        send_frame(CMD_CALIBRATE, flat_frame(2000));
        fr = flat_frame(2000);
        fr[2] = ADC_W'(2001);
        send_frame(CMD_MEASURE, fr);
        send_frame(CMD_MEASURE, flat_frame(1999));
    endtask

    task automatic test_calibrated_range();
        frame_t fr;
        send_frame(CMD_CALIBRATE, flat_frame(1000));
        send_frame(CMD_CALIBRATE, flat_frame(3000));
        // below, at and above each end of the range
        fr = {12'd4095, 12'd3001, 12'd3000, 12'd2999, 12'd2000, 12'd1001, 12'd1000, 12'd0};
        send_frame(CMD_MEASURE, fr);
        fr = flat_frame(1000);
        fr[0] = ADC_W'(3000);
        send_frame(CMD_MEASURE, fr);
        fr = flat_frame(1000);
        fr[NUM_SENSORS-1] = ADC_W'(3000);
        send_frame(CMD_MEASURE, fr);
    endtask

    task automatic test_registers();
        frame_t fr;
        write_reg(REG_DETECT_THRESHOLD, CFG_W'(0));
        fr = flat_frame(1000);
        fr[4] = ADC_W'(1002);
        send_frame(CMD_MEASURE, fr);
        // nothing can exceed a full-scale threshold
        write_reg(REG_DETECT_THRESHOLD, CFG_W'(FULL_SCALE));
        send_frame(CMD_MEASURE, flat_frame(ADC_TOP));
        write_reg(REG_CENTER_POSITION, CFG_W'(8191));
        send_frame(CMD_MEASURE, flat_frame(ADC_TOP));
        write_reg(REG_CENTER_POSITION, CFG_W'(0));
        send_frame(CMD_MEASURE, flat_frame(ADC_TOP));
        write_reg(REG_DETECT_THRESHOLD, CFG_W'(1023));
        write_reg(REG_CENTER_POSITION, CFG_W'(4000));
        send_frame(CMD_MEASURE, flat_frame(ADC_TOP));
        write_reg(REG_LINE_IS_WHITE, CFG_W'(13'h1FFF));
        write_reg(REG_DETECT_THRESHOLD, CFG_W'(999));
        send_frame(CMD_MEASURE, flat_frame(1000));
        // an unused index must leave every register alone
        write_reg(REG_SPARE, CFG_W'(13'h1FFF));
        send_frame(CMD_MEASURE, flat_frame(1000));
        write_reg(REG_LINE_IS_WHITE, CFG_W'(13'h1FFE));
        write_reg(REG_CENTER_POSITION, CFG_W'(MAX_POS));
        send_frame(CMD_MEASURE, flat_frame(1000));
    endtask

    task automatic shuffle_registers();
        int r;
        write_reg(REG_LINE_IS_WHITE, CFG_W'($urandom));
        r = $urandom_range(0, 99);
        if (r < 10)
            write_reg(REG_CENTER_POSITION, CFG_W'(0));
        else if (r < 20)
            write_reg(REG_CENTER_POSITION, CFG_W'(MAX_POS));
        else
            write_reg(REG_CENTER_POSITION, CFG_W'($urandom_range(0, MAX_POS)));
        r = $urandom_range(0, 99);
        if (r < 10)
            write_reg(REG_DETECT_THRESHOLD, CFG_W'(0));
        else if (r < 15)
            write_reg(REG_DETECT_THRESHOLD, CFG_W'(FULL_SCALE));
        else
            write_reg(REG_DETECT_THRESHOLD, CFG_W'($urandom_range(50, 800)));
    endtask

    task automatic test_random_frames(input int idle, input int stall, input bit wide_cal);
        int r;
        send_idle_pct  = idle;
        sink_stall_pct = stall;
        for (int n = 0; n < PHASE_FRAMES; n++)
        begin
            if (n % CHUNK == 0)
                shuffle_registers();
            r = $urandom_range(0, 99);
            if (wide_cal && r < 1)
                send_frame(CMD_CALIBRATE, noise_frame());
            else if (r < 20)
                send_frame(CMD_CALIBRATE, band_frame());
            else if (r < 85)
                send_frame(CMD_MEASURE, line_frame(white_line));
            else
                send_frame(CMD_MEASURE, noise_frame());
        end
    endtask

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);

    always @(posedge clk)
    begin
        line_fix_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_fixes.size() == 0)
            begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("unexpected result: position %0d line_lost %0b",
                             position, line_lost);
            end
            else
            begin
                want = expected_fixes.pop_front();
                fixes_seen++;
                if (want.line_lost)
                    lost_seen++;
                if (position !== want.position || line_lost !== want.line_lost)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display("mismatch: expected position %0d line_lost %0b, got %0d %0b",
                                 want.position, want.line_lost, position, line_lost);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stalled_cycles = 0;
        else
            stalled_cycles++;
        if (stalled_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("line_sensor_position_estimator_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        command   <= CMD_CALIBRATE;
        frame_bus <= '0;
        out_ready <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            cal_lo[i] = ADC_W'(ADC_TOP);
            cal_hi[i] = '0;
        end
        last_fix   = POS_W'(LAST_RST);
        white_line = 1'b0;
        centre_pos = POS_W'(CENTER_RST);
        threshold  = THR_W'(THR_RST);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_uncalibrated();
        test_single_frame_calibration();
        test_calibrated_range();
        test_registers();
        test_random_frames(29, 69, 1'b0);
        test_random_frames(69, 29, 1'b0);
        test_random_frames(0, 0, 1'b1);

        in_valid <= 1'b0;
        while (expected_fixes.size() != 0)
            @(posedge clk);
        repeat (HOLD_OFF) @(posedge clk);

        $display("covered %0d measure and %0d calibrate items over %0d register writes",
                 measures_sent, cal_frames, reg_writes);
        $display("checked %0d positions, %0d of them with the line lost", fixes_seen, lost_seen);
        if (fault_count == 0)
            $display("line_sensor_position_estimator_tb: done, clean");
        else
            $display("line_sensor_position_estimator_tb: done, errors");
        $finish;
    end

endmodule
